// ===== rtl/soperc_pkg.sv =====
// ----------------------------------------------------------------------------
// soperc_pkg
// Shared types, constants and fixed-point helpers for the second-order
// perceptron update core.
// ----------------------------------------------------------------------------
package soperc_pkg;

  localparam int MAX_DIM_DEF   = 64;
  localparam int FRAC_BITS_DEF = 16;

  localparam int              CFG_W     = 7;
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  // item queue between front and back
  localparam int Q_DEPTH = 2;

  // divider steps, one quotient bit each
  localparam int DIV_STEPS = 64;
  localparam int DIV_CNT_W = 6;

  typedef struct packed {
    logic signed [31:0] feature_value;
    logic               label_positive;
  } in_item_t;

  typedef struct packed {
    logic predicted_positive;
    logic mistake;
  } out_item_t;

  // nm1: sample length minus one, valid on the item that completes a sample
  typedef struct packed {
    in_item_t         item;
    logic             last;
    logic [CFG_W-1:0] nm1;
  } q_entry_t;

  typedef enum logic [1:0] {
    OP_SIGMA,
    OP_V,
    OP_F
  } mac_op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SX,
    ST_V,
    ST_F,
    ST_DRAIN,
    ST_POST,
    ST_U_RD,
    ST_U_MUL,
    ST_U_GO,
    ST_U_DIV,
    ST_U_WR,
    ST_W_RD,
    ST_W_WR
  } back_state_t;

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if ((a[63] == b[63]) && (s[63] != a[63])) begin
      s = a[63] ? {1'b1, {63{1'b0}}} : {1'b0, {63{1'b1}}};
    end
    return s;
  endfunction

  // floor shift by fb, then saturate to 32 bits
  function automatic logic signed [31:0] fx_narrow(input logic signed [63:0] a,
                                                   input int unsigned fb);
    logic signed [63:0] sh;
    logic signed [31:0] r;
    sh = a >>> fb;
    if (sh > 64'sh000000007FFFFFFF) begin
      r = 32'sh7FFFFFFF;
    end else if (sh < -64'sh0000000080000000) begin
      r = 32'sh80000000;
    end else begin
      r = sh[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat32_33(input logic signed [32:0] a);
    logic signed [31:0] r;
    if (a[32] != a[31]) begin
      r = a[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
    end else begin
      r = a[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat32_66(input logic signed [65:0] a);
    logic signed [31:0] r;
    if (a > 66'sh0000000007FFFFFFF) begin
      r = 32'sh7FFFFFFF;
    end else if (a < -66'sh00000000080000000) begin
      r = 32'sh80000000;
    end else begin
      r = a[31:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/soperc_queue.sv =====
// ----------------------------------------------------------------------------
// soperc_queue
// Short item queue between the front and the back.
// ----------------------------------------------------------------------------
module soperc_queue import soperc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t wdata,
  output logic     full,
  input  logic     pop,
  output logic     empty,
  output q_entry_t rdata
);

  localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CW = $clog2(Q_DEPTH + 1);

  q_entry_t        mem_r [Q_DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   cnt_r;
  logic            do_push, do_pop;

  assign full    = (cnt_r == CW'(Q_DEPTH));
  assign empty   = (cnt_r == '0);
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + CW'(do_push) - CW'(do_pop);
    end
  end

endmodule

// ===== rtl/soperc_front.sv =====
// ----------------------------------------------------------------------------
// soperc_front
// Accepts feature items, holds the feature count register and marks the
// item that completes a sample.
// ----------------------------------------------------------------------------
module soperc_front import soperc_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             in_push,
  input  in_item_t         in_item,
  output logic             in_full,
  input  logic             q_full,
  input  logic             clearing,
  output logic             q_push,
  output q_entry_t         q_entry
);

  localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int LW = IW + CFG_W + 1;

  logic [CFG_W-1:0] count_r;
  logic [IW-1:0]    idx_r;
  logic [LW-1:0]    n_eff, idx_inc;
  logic             last;

  always_comb begin
    if (count_r == '0) begin
      n_eff = LW'(1);
    end else if (LW'(count_r) > LW'(MAX_DIM)) begin
      n_eff = LW'(MAX_DIM);
    end else begin
      n_eff = LW'(count_r);
    end
  end

  assign idx_inc         = LW'(idx_r) + LW'(1);
  assign last            = (idx_inc >= n_eff);
  assign in_full         = q_full || clearing;
  assign q_push          = in_push && !in_full;
  assign q_entry.item    = in_item;
  assign q_entry.last    = last;
  // a count shortened mid-sample still sets the sample length
  assign q_entry.nm1     = CFG_W'(n_eff - LW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= CFG_RESET;
      idx_r   <= '0;
    end else begin
      if (cfg_we) begin
        count_r <= cfg_wdata;
      end
      if (q_push) begin
        idx_r <= last ? '0 : idx_r + 1'b1;
      end
    end
  end

endmodule

// ===== rtl/soperc_div.sv =====
// ----------------------------------------------------------------------------
// soperc_div
// Signed 64 / 32 divider, truncating toward zero, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module soperc_div import soperc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [63:0] num,
  input  logic signed [31:0] den,
  output logic               done,
  output logic signed [63:0] quot
);

  logic [63:0]          a_r;
  logic [31:0]          d_r;
  logic [31:0]          rem_r;
  logic                 neg_r;
  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [32:0]          rem_sh;
  logic                 ge;

  assign rem_sh = {rem_r, a_r[63]};
  assign ge     = (rem_sh >= {1'b0, d_r});
  assign done   = done_r;
  assign quot   = neg_r ? -$signed(a_r) : $signed(a_r);

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= num[63] ? (~num + 64'd1) : num;
      d_r   <= den[31] ? (~den + 32'd1) : den;
      rem_r <= '0;
      neg_r <= num[63] ^ den[31];
    end else if (busy_r) begin
      rem_r <= ge ? 32'(rem_sh - {1'b0, d_r}) : rem_sh[31:0];
      a_r   <= {a_r[62:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIV_STEPS - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/soperc_back.sv =====
// ----------------------------------------------------------------------------
// soperc_back
// Sample engine: stores features, runs the dot products through a MAC
// pipeline, posts the result and updates Sigma and the weights.
// ----------------------------------------------------------------------------
module soperc_back import soperc_pkg::*; #(
  parameter int MAX_DIM   = MAX_DIM_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  q_entry_t  q_entry,
  output logic      q_pop,
  output logic      clearing,
  input  logic      out_pop,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int IW     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int SDEPTH = MAX_DIM * MAX_DIM;
  localparam int SAW    = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
  localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

  back_state_t state_r, state_nxt, after_r;

  logic [IW-1:0] i_r, k_r, wr_idx_r, nm1_r;
  logic          label_r, miss_r, fneg_r;
  logic          last_k, last_i;

  // memories
  logic signed [31:0] sigma_mem [SDEPTH];
  logic signed [31:0] x_mem     [MAX_DIM];
  logic signed [31:0] s_mem     [MAX_DIM];
  logic signed [31:0] w_mem     [MAX_DIM];

  logic signed [31:0] sig_rd_r, x_rd_r, w_rd_r, sa_rd_r, sb_rd_r;
  logic [SAW-1:0]     sig_ra;

  // MAC pipeline tags
  logic          iss_vld;
  mac_op_t       iss_op;
  logic          p1_vld_r, p1_first_r, p1_last_r;
  mac_op_t       p1_op_r;
  logic [IW-1:0] p1_row_r;
  logic          p2_vld_r, p2_first_r, p2_last_r;
  mac_op_t       p2_op_r;
  logic [IW-1:0] p2_row_r;

  logic signed [63:0] prod_r, acc_r, acc_fin, mul_res;
  logic signed [31:0] mul_a, mul_b;
  logic signed [31:0] v_r, den_r, den_c;
  logic signed [63:0] num_r;
  logic               pred_c, miss_c;

  // write controls
  logic               sig_we, w_we, s_we;
  logic signed [31:0] sig_wd, w_wd;

  logic               div_start, div_done;
  logic signed [63:0] div_quot;

  logic        out_valid_r;
  out_item_t   out_item_r;

  assign last_k = (k_r == nm1_r);
  assign last_i = (i_r == nm1_r);
  assign sig_ra = SAW'(i_r) * SAW'(MAX_DIM) + SAW'(k_r);

  assign den_c  = sat32_33(33'(v_r) + 33'(ONE));
  assign pred_c = !fneg_r;
  assign miss_c = (pred_c != label_r);

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (i_r == IW'(MAX_DIM - 1) && k_r == IW'(MAX_DIM - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (!q_empty && q_entry.last) state_nxt = ST_SX;
      end
      ST_SX: begin
        if (last_k && last_i) state_nxt = ST_DRAIN;
      end
      ST_V, ST_F: begin
        if (last_k) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!p1_vld_r && !p2_vld_r) state_nxt = after_r;
      end
      ST_POST: begin
        if (!out_valid_r) begin
          if (den_c != '0)  state_nxt = ST_U_RD;
          else if (miss_c)  state_nxt = ST_W_RD;
          else              state_nxt = ST_IDLE;
        end
      end
      ST_U_RD:  state_nxt = ST_U_MUL;
      ST_U_MUL: state_nxt = ST_U_GO;
      ST_U_GO:  state_nxt = ST_U_DIV;
      ST_U_DIV: begin
        if (div_done) state_nxt = ST_U_WR;
      end
      ST_U_WR: begin
        if (!(last_k && last_i)) state_nxt = ST_U_RD;
        else if (miss_r)         state_nxt = ST_W_RD;
        else                     state_nxt = ST_IDLE;
      end
      ST_W_RD: state_nxt = ST_W_WR;
      ST_W_WR: begin
        state_nxt = last_k ? ST_IDLE : ST_W_RD;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // ---------------- outputs of the sequencer ----------------
  always_comb begin
    q_pop     = 1'b0;
    clearing  = 1'b0;
    iss_vld   = 1'b0;
    iss_op    = OP_SIGMA;
    div_start = 1'b0;
    sig_we    = 1'b0;
    sig_wd    = sat32_66(66'(sig_rd_r) - 66'(div_quot));
    w_we      = 1'b0;
    w_wd      = label_r ? sat32_33(33'(w_rd_r) + 33'(x_rd_r))
                        : sat32_33(33'(w_rd_r) - 33'(x_rd_r));
    unique case (state_r)
      ST_CLEAR: begin
        clearing = 1'b1;
        sig_we   = 1'b1;
        sig_wd   = (i_r == k_r) ? ONE : '0;
        w_we     = (i_r == '0);
        w_wd     = '0;
      end
      ST_IDLE:  q_pop = !q_empty;
      ST_SX: begin
        iss_vld = 1'b1;
        iss_op  = OP_SIGMA;
      end
      ST_V: begin
        iss_vld = 1'b1;
        iss_op  = OP_V;
      end
      ST_F: begin
        iss_vld = 1'b1;
        iss_op  = OP_F;
      end
      ST_U_GO:  div_start = 1'b1;
      ST_U_WR:  sig_we = 1'b1;
      ST_W_WR:  w_we = 1'b1;
      default: ;
    endcase
  end

  // ---------------- memories ----------------
  always_ff @(posedge clk) begin
    if (sig_we) begin
      sigma_mem[sig_ra] <= sig_wd;
    end
    sig_rd_r <= sigma_mem[sig_ra];
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      x_mem[wr_idx_r] <= q_entry.item.feature_value;
    end
    x_rd_r <= x_mem[k_r];
  end

  always_ff @(posedge clk) begin
    if (w_we) begin
      w_mem[k_r] <= w_wd;
    end
    w_rd_r <= w_mem[k_r];
  end

  always_ff @(posedge clk) begin
    if (s_we) begin
      s_mem[p2_row_r] <= fx_narrow(acc_fin, FRAC_BITS);
    end
    sa_rd_r <= s_mem[k_r];
    sb_rd_r <= s_mem[i_r];
  end

  // ---------------- MAC datapath ----------------
  always_comb begin
    case (p1_op_r)
      OP_SIGMA: begin
        mul_a = sig_rd_r;
        mul_b = x_rd_r;
      end
      OP_V: begin
        mul_a = x_rd_r;
        mul_b = sa_rd_r;
      end
      default: begin
        mul_a = w_rd_r;
        mul_b = sa_rd_r;
      end
    endcase
  end

  assign mul_res = mul_a * mul_b;
  assign acc_fin = sat_add64(p2_first_r ? 64'sd0 : acc_r, prod_r);
  assign s_we    = p2_vld_r && p2_last_r && (p2_op_r == OP_SIGMA);

  always_ff @(posedge clk) begin
    prod_r     <= mul_res;
    p1_first_r <= (k_r == '0);
    p1_last_r  <= last_k;
    p1_op_r    <= iss_op;
    p1_row_r   <= i_r;
    p2_first_r <= p1_first_r;
    p2_last_r  <= p1_last_r;
    p2_op_r    <= p1_op_r;
    p2_row_r   <= p1_row_r;
    if (p2_vld_r) begin
      acc_r <= acc_fin;
    end
    if (p2_vld_r && p2_last_r && p2_op_r == OP_V) begin
      v_r <= fx_narrow(acc_fin, FRAC_BITS);
    end
    if (p2_vld_r && p2_last_r && p2_op_r == OP_F) begin
      fneg_r <= acc_fin[63];
    end
    if (state_r == ST_U_MUL) begin
      num_r <= sa_rd_r * sb_rd_r;
    end
    // the output register still holding an item is left alone
    if (state_r == ST_POST && !out_valid_r) begin
      den_r      <= den_c;
      miss_r     <= miss_c;
      out_item_r <= '{predicted_positive: pred_c, mistake: miss_c};
    end
    if (q_pop && q_entry.last) begin
      label_r <= q_entry.item.label_positive;
    end
  end

  soperc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_r),
    .den   (den_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  // ---------------- control registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      after_r     <= ST_V;
      i_r         <= '0;
      k_r         <= '0;
      wr_idx_r    <= '0;
      nm1_r       <= '0;
      p1_vld_r    <= 1'b0;
      p2_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      p1_vld_r <= iss_vld;
      p2_vld_r <= p1_vld_r;
      if (out_pop && out_valid_r) begin
        out_valid_r <= 1'b0;
      end else if (state_r == ST_POST && !out_valid_r) begin
        out_valid_r <= 1'b1;
      end
      case (state_r)
        ST_CLEAR: begin
          if (k_r == IW'(MAX_DIM - 1)) begin
            k_r <= '0;
            i_r <= (i_r == IW'(MAX_DIM - 1)) ? '0 : i_r + 1'b1;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        ST_IDLE: begin
          if (q_pop) begin
            if (q_entry.last) begin
              wr_idx_r <= '0;
              nm1_r    <= IW'(q_entry.nm1);
              i_r      <= '0;
              k_r      <= '0;
            end else begin
              wr_idx_r <= wr_idx_r + 1'b1;
            end
          end
        end
        ST_SX, ST_U_WR: begin
          if (last_k) begin
            k_r <= '0;
            i_r <= last_i ? '0 : i_r + 1'b1;
            if (last_i) after_r <= ST_V;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        ST_V: begin
          k_r <= last_k ? '0 : k_r + 1'b1;
          if (last_k) after_r <= ST_F;
        end
        ST_F: begin
          k_r <= last_k ? '0 : k_r + 1'b1;
          if (last_k) after_r <= ST_POST;
        end
        ST_W_WR: begin
          k_r <= last_k ? '0 : k_r + 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== rtl/second_order_perceptron_update_core.sv =====
// ----------------------------------------------------------------------------
// second_order_perceptron_update_core
// Online second-order perceptron with weights and Sigma held on chip.
//
// Use: push one feature item per cycle (in_push, when in_full is low), in
// index order; the label rides on every item and the one on the item that
// completes a sample counts. feature_count (cfg_we/cfg_wdata) sets the
// sample length, 0 meaning 1 and values above MAX_DIM meaning MAX_DIM.
// Each completed sample yields one result item on out_item while out_empty
// is low; out_pop takes it. Other items give no result.
// Flow: the front takes items into a short queue; the back buffers a
// feature per cycle while idle, then computes s, v and f, posts the
// result, then updates Sigma one entry at a time through the shared
// 64-step divider (skipped when v + 1.0 is zero) and then w (on a
// mistake only); it pops no new item until the update is done.
// Reset: a clearing pass over the MAX_DIM*MAX_DIM Sigma entries loads
// Sigma with the identity and w with zero; in_full stays high through it.
// A stalled receiver holds the result in the output register; the back
// waits before posting the next one, and the queue then fills.
// ----------------------------------------------------------------------------
module second_order_perceptron_update_core import soperc_pkg::*; #(
  parameter int MAX_DIM   = MAX_DIM_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  input  in_item_t         in_item,
  output logic             in_full,
  output logic             out_empty,
  input  logic             out_pop,
  output out_item_t        out_item,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  logic     q_push, q_full, q_pop, q_empty, clearing, out_valid;
  q_entry_t q_wdata, q_rdata;

  // front: count register, sample boundary marking
  soperc_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_push   (in_push),
    .in_item   (in_item),
    .in_full   (in_full),
    .q_full    (q_full),
    .clearing  (clearing),
    .q_push    (q_push),
    .q_entry   (q_wdata)
  );

  // decouples item intake from the sample engine
  soperc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  soperc_back #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_entry   (q_rdata),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .out_pop   (out_pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  assign out_empty = !out_valid;

endmodule

// ===== tb/tb_second_order_perceptron_update_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_second_order_perceptron_update_core
// Self-checking bench for the second-order perceptron core. Feature items
// are streamed through the push/full side and a bit-exact predictor (Sigma,
// w, saturating Q16.16 math) computes each sample's prediction and mistake
// flag. Results are popped and compared in order. The sample length register
// is swept through its extremes, both sides idle at random, and one long
// receiver hold-off backs the core up into its input.
// ----------------------------------------------------------------------------
module tb_second_order_perceptron_update_core;
  import soperc_pkg::*;

  localparam int  DIM      = MAX_DIM_DEF;
  localparam int  FB       = FRAC_BITS_DEF;
  localparam int  ONE_Q    = 1 << FB;
  localparam int  N_RAND   = 750;
  localparam longint LIMIT = 64'd4_000_000;
  localparam longint S64_MAX = 64'sh7FFFFFFFFFFFFFFF;
  localparam longint S64_MIN = -64'sh7FFFFFFFFFFFFFFF - 1;

  logic             clk;
  logic             rst_n;
  logic             in_push;
  in_item_t         in_item;
  logic             in_full;
  logic             out_empty;
  logic             out_pop;
  out_item_t        out_item;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  second_order_perceptron_update_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_item  (in_item),
    .in_full  (in_full),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // 12 ns clock
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // --------------------------------------------------------------------------
  // Predictor state: its own copy of the sample, Sigma, s and w.
  // --------------------------------------------------------------------------
  int               x_buf [DIM];
  int               s_vec [DIM];
  int               w_vec [DIM];
  int               sigma [DIM*DIM];
  int unsigned      feat_pos;
  logic [CFG_W-1:0] count_reg;

  in_item_t  feature_q[$];   // items waiting to be pushed
  out_item_t verdict_q[$];   // predicted results, oldest first

  int     tx_idle, rx_idle;  // idle odds in percent
  int     rx_hold;           // long hold-off, counted in the receiver
  bit     rx_hold_req;
  bit     took;              // item accepted at the last rising edge
  longint cycles;
  int     errors, n_results, n_samples, n_items, rand_items, cur_d;

  function automatic int sat32(longint a);
    if (a > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (a < -64'sd2147483648) return 32'sh80000000;
    return int'(a);
  endfunction

  function automatic longint sadd64(longint a, longint b);
    if (b > 0 && a > S64_MAX - b) return S64_MAX;
    if (b < 0 && a < S64_MIN - b) return S64_MIN;
    return a + b;
  endfunction

  // floor shift then saturate
  function automatic int q_narrow(longint a);
    return sat32(a >>> FB);
  endfunction

  function automatic int eff_count(logic [CFG_W-1:0] c);
    if (c == 0) return 1;
    if (c > DIM) return DIM;
    return int'(c);
  endfunction

  // One accepted feature item; a completed sample queues its verdict.
  task automatic perceptron_step(in_item_t it);
    int        n, v, den;
    longint    acc, f_acc, num;
    out_item_t r;
    n = eff_count(count_reg);
    x_buf[feat_pos % DIM] = it.feature_value;
    feat_pos = (feat_pos % DIM) + 1;
    if (feat_pos < n) return;
    feat_pos = 0;
    // s = Sigma x
    for (int i = 0; i < n; i++) begin
      acc = 0;
      for (int k = 0; k < n; k++)
        acc = sadd64(acc, longint'(sigma[i*DIM+k]) * longint'(x_buf[k]));
      s_vec[i] = q_narrow(acc);
    end
    acc = 0;
    f_acc = 0;
    for (int k = 0; k < n; k++) begin
      acc   = sadd64(acc, longint'(x_buf[k]) * longint'(s_vec[k]));
      f_acc = sadd64(f_acc, longint'(w_vec[k]) * longint'(s_vec[k]));
    end
    v = q_narrow(acc);
    r.predicted_positive = (f_acc >= 0);
    r.mistake = (r.predicted_positive != it.label_positive);
    // rank-one update, skipped on a zero denominator
    den = sat32(longint'(v) + ONE_Q);
    if (den != 0) begin
      for (int i = 0; i < n; i++)
        for (int j = 0; j < n; j++) begin
          num = longint'(s_vec[i]) * longint'(s_vec[j]);
          sigma[i*DIM+j] = sat32(longint'(sigma[i*DIM+j]) - num / longint'(den));
        end
    end
    if (r.mistake) begin
      for (int i = 0; i < n; i++)
        w_vec[i] = sat32(it.label_positive ? longint'(w_vec[i]) + x_buf[i]
                                           : longint'(w_vec[i]) - x_buf[i]);
    end
    verdict_q.push_back(r);
    n_samples++;
  endtask

  // --------------------------------------------------------------------------
  // Sampling at the rising edge: accepts, config writes, result checks.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t want;
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_second_order_perceptron_update_core: errors");
      $finish;
    end else begin
      took = rst_n && in_push && !in_full;
      if (rst_n && cfg_we) count_reg = cfg_wdata;
      if (took) begin
        n_items++;
        perceptron_step(in_item);
      end
      if (rst_n && out_pop && !out_empty) begin
        n_results++;
        if (verdict_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %b at cycle %0d", out_item, cycles);
        end else begin
          want = verdict_q.pop_front();
          if (out_item.predicted_positive !== want.predicted_positive ||
              out_item.mistake !== want.mistake) begin
            errors++;
            if (errors <= 10)
              $display("result %0d: pred exp %b got %b, mistake exp %b got %b",
                       n_results, want.predicted_positive, out_item.predicted_positive,
                       want.mistake, out_item.mistake);
          end
        end
      end
    end
  end

  // Driver: holds an offered item until it is taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else if (!(in_push && !took)) begin
      if (feature_q.size() > 0 && $urandom_range(99) >= tx_idle) begin
        in_item <= feature_q.pop_front();
        in_push <= 1'b1;
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // Receiver: random pops, plus the long hold-off on request.
  always @(negedge clk) begin
    if (rx_hold_req) begin
      rx_hold     = 3000;
      rx_hold_req = 1'b0;
    end
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold--;
      out_pop <= 1'b0;
    end else begin
      out_pop <= ($urandom_range(99) >= rx_idle);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  function automatic int rand_feature();
    int sel;
    sel = $urandom_range(99);
    if (sel < 60) return $urandom_range(8 * ONE_Q) - 4 * ONE_Q;   // +/-4.0
    if (sel < 80) return $urandom_range(512 * ONE_Q) - 256 * ONE_Q;
    return $urandom;                                              // any pattern
  endfunction

  task automatic push_feature(int x, bit y);
    in_item_t it;
    it.feature_value  = x;
    it.label_positive = y;
    feature_q.push_back(it);
  endtask

  task automatic queue_sample(int d);
    for (int k = 0; k < d; k++) begin
      push_feature(rand_feature(), $urandom_range(1));
      rand_items++;
    end
  endtask

  task automatic wait_idle();
    while (feature_q.size() != 0 || in_push || verdict_q.size() != 0)
      @(posedge clk);
  endtask

  // Let any Sigma update finish, then write the sample length.
  task automatic write_count(logic [CFG_W-1:0] c);
    wait_idle();
    repeat (70 * cur_d * cur_d + 4 * cur_d + 60) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= c;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_d = eff_count(c);
  endtask

  // Feature that drives v to -1.0 for a one-feature sample, if one exists.
  function automatic int zero_den_feature();
    int s, v;
    for (int x = -3000; x <= 3000; x++) begin
      s = q_narrow(longint'(sigma[0]) * x);
      v = q_narrow(longint'(x) * s);
      if (v == -ONE_Q) return x;
    end
    return 362;
  endfunction

  initial begin
    int d, sel, nsamp;
    in_push   = 1'b0;
    in_item   = '0;
    out_pop   = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    rst_n     = 1'b0;
    took      = 1'b0;
    rx_hold   = 0;
    rx_hold_req = 1'b0;
    tx_idle   = 0;
    rx_idle   = 0;
    cycles    = 0;
    errors = 0; n_results = 0; n_samples = 0; n_items = 0; rand_items = 0;
    for (int i = 0; i < DIM; i++) begin
      x_buf[i] = 0;
      s_vec[i] = 0;
      w_vec[i] = 0;
    end
    for (int i = 0; i < DIM * DIM; i++) sigma[i] = (i % (DIM + 1) == 0) ? ONE_Q : 0;
    feat_pos  = 0;
    count_reg = CFG_RESET;
    cur_d     = DIM;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: zero count acts as one feature; the field extremes.
    cur_d = 0;
    write_count(7'd0);
    push_feature(32'sh7FFFFFFF, 1'b1);
    push_feature(32'sh80000000, 1'b0);
    push_feature(0, 1'b1);
    push_feature(-1, 1'b0);
    // Count above the built size, then shortened mid-sample.
    write_count(7'd127);
    push_feature(3 * ONE_Q, 1'b1);
    push_feature(-2 * ONE_Q, 1'b0);
    push_feature(ONE_Q / 2, 1'b1);
    write_count(7'd2);
    push_feature(ONE_Q, 1'b0);
    // Zero denominator: drive Sigma negative, then aim v at -1.0.
    write_count(7'd1);
    push_feature(32'sh7FFFFFFF, 1'b1);
    wait_idle();
    push_feature(zero_den_feature(), 1'b0);
    push_feature(zero_den_feature(), 1'b1);
    write_count(7'd3);
    for (int k = 0; k < 6; k++) push_feature(rand_feature(), k[0]);

    // Random phases: mostly short samples, a few longer ones.
    tx_idle = 34;
    rx_idle = 82;
    while (rand_items < N_RAND) begin
      sel = $urandom_range(99);
      if (sel < 70) d = $urandom_range(1, 4);
      else if (sel < 95) d = $urandom_range(5, 8);
      else d = $urandom_range(12, 16);
      write_count((d == 1 && $urandom_range(1)) ? 7'd0 : 7'(d));
      nsamp = (40 / d < 2) ? 2 : 40 / d;
      for (int k = 0; k < nsamp; k++) queue_sample(d);
      if (rand_items >= 2 * N_RAND / 3) begin
        tx_idle = 0;
        rx_idle = 0;
      end else if (rand_items >= N_RAND / 3) begin
        tx_idle = 82;
        rx_idle = 34;
      end
    end

    // Receiver stalls long while single-feature samples keep coming.
    tx_idle = 0;
    rx_idle = 0;
    write_count(7'd1);
    rx_hold_req = 1'b1;
    for (int k = 0; k < 30; k++) queue_sample(1);

    // One sample at the full built dimension.
    write_count(7'd64);
    queue_sample(DIM);

    wait_idle();
    repeat (200) @(posedge clk);
    $display("%0d feature items, %0d samples checked over lengths 1..64", n_items, n_results);
    $display("%0d mismatches, %0d results still pending", errors, verdict_q.size());
    if (errors == 0 && verdict_q.size() == 0) begin
      $display("tb_second_order_perceptron_update_core: clean");
    end else begin
      $display("tb_second_order_perceptron_update_core: errors");
    end
    $finish;
  end

endmodule
